>>> sv/rrts_pkg.sv
// shared constants and types for the round-robin tick scheduler
`default_nettype none
package rrts_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W = 8;
	localparam int TIME_W = 16;
	localparam int ENTRY_W = ID_W + TIME_W;

	localparam logic [TIME_W-1:0] RUN_LENGTH_RESET = TIME_W'(100);

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic read;
		logic exec;
	} dp_cmd_t;

endpackage
`default_nettype wire

>>> sv/round_robin_tick_scheduler.sv
// top level of the round-robin scheduler with a one-tick time slice
// an arrive goes from acceptance straight to the single execute step, a tick first through the
// queue ram registered read; no new request is taken until the previous one has left the
// execute step and the block is idle again
// a stalled result holds the execute step, so the next request waits for the result slot
// reset: arst_n clears pointers, count and tick counter, run length returns to 100
`default_nettype none
module round_robin_tick_scheduler import rrts_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TIME_W-1:0] cfg_wdata,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              command,
	input  wire logic [ID_W-1:0]   job_id,
	input  wire logic [TIME_W-1:0] burst_time,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic                   was_tick,
	output logic      [TIME_W-1:0] tick_time,
	output logic                   idle,
	output logic      [ID_W-1:0]   running_id,
	output logic                   finished,
	output logic                   last_tick,
	output logic                   window_over,
	output logic                   arrival_dropped
);

	dp_cmd_t cmd;

	rrts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_command(command),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cmd        (cmd)
	);

	rrts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.command        (command),
		.job_id         (job_id),
		.burst_time     (burst_time),
		.was_tick       (was_tick),
		.tick_time      (tick_time),
		.idle           (idle),
		.running_id     (running_id),
		.finished       (finished),
		.last_tick      (last_tick),
		.window_over    (window_over),
		.arrival_dropped(arrival_dropped)
	);

endmodule
`default_nettype wire

>>> sv/rrts_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/rrts_ctrl.sv
// controller state machine: request acceptance, queue read, execute and result handoff
`default_nettype none
module rrts_ctrl import rrts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_command,
	output logic      req_stall,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output dp_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   exec_fire;

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	// the result slot is free when empty or being taken this cycle
	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || !rsp_stall);
	assign rsp_valid = out_valid_q;

	assign cmd.load = accept;
	assign cmd.read = (state_q == S_READ);
	assign cmd.exec = exec_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						// a tick needs the head entry, an arrive does not
						state_q <= (req_command == CMD_TICK) ? S_READ : S_EXEC;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/rrts_dp.sv
// datapath: ready queue pointers, tick counter, run length and result registers
`default_nettype none
module rrts_dp import rrts_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	input  wire logic              cfg_we,
	input  wire logic [TIME_W-1:0] cfg_wdata,
	input  wire logic              command,
	input  wire logic [ID_W-1:0]   job_id,
	input  wire logic [TIME_W-1:0] burst_time,
	output logic                   was_tick,
	output logic      [TIME_W-1:0] tick_time,
	output logic                   idle,
	output logic      [ID_W-1:0]   running_id,
	output logic                   finished,
	output logic                   last_tick,
	output logic                   window_over,
	output logic                   arrival_dropped
);

	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] tick_q;
	logic [TIME_W-1:0] run_len_q;

	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] burst_q;

	logic [ENTRY_W-1:0] rd_entry;
	logic [ID_W-1:0]    head_id;
	logic [TIME_W-1:0]  head_rem;
	logic [TIME_W-1:0]  rem_next;

	logic               wr_en;
	logic [ENTRY_W-1:0] wr_entry;
	logic [PTR_W-1:0]   head_inc;
	logic [PTR_W-1:0]   tail_inc;

	logic full;
	logic empty;
	logic past_window;
	logic at_last;

	logic              r_tick;
	logic              r_idle;
	logic [ID_W-1:0]   r_id;
	logic              r_fin;
	logic              r_last;
	logic              r_over;
	logic              r_drop;

	rrts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tail_q),
		.wdata(wr_entry),
		.re   (cmd.read),
		.raddr(head_q),
		.rdata(rd_entry)
	);

	assign head_id = rd_entry[ENTRY_W-1:TIME_W];
	assign head_rem = rd_entry[TIME_W-1:0];
	assign rem_next = (head_rem != '0) ? head_rem - TIME_W'(1) : '0;

	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign past_window = (tick_q >= run_len_q);
	assign at_last = (({1'b0, tick_q} + (TIME_W + 1)'(1)) == {1'b0, run_len_q});

	always_comb begin
		wr_en = 1'b0;
		wr_entry = {id_q, (burst_q == '0) ? TIME_W'(1) : burst_q};
		r_tick = 1'b0;
		r_idle = 1'b0;
		r_id = '0;
		r_fin = 1'b0;
		r_last = 1'b0;
		r_over = 1'b0;
		r_drop = 1'b0;
		if (cmd_q == CMD_ARRIVE) begin
			r_drop = full;
			wr_en = cmd.exec && !full;
		end else begin
			r_tick = 1'b1;
			if (past_window) begin
				r_over = 1'b1;
			end else begin
				r_last = at_last;
				if (empty) begin
					r_idle = 1'b1;
				end else begin
					r_id = head_id;
					r_fin = (rem_next == '0);
					// job with time left goes back to the tail
					wr_entry = {head_id, rem_next};
					wr_en = cmd.exec && (rem_next != '0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			tick_q <= '0;
			run_len_q <= RUN_LENGTH_RESET;
		end else begin
			if (cfg_we) begin
				run_len_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				if (wr_en) begin
					tail_q <= tail_inc;
				end
				if (cmd_q == CMD_ARRIVE) begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else if (!past_window) begin
					tick_q <= tick_q + TIME_W'(1);
					if (!empty) begin
						head_q <= head_inc;
						if (rem_next == '0) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
			end
		end
	end

	// transaction capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			id_q <= job_id;
			burst_q <= burst_time;
		end
		if (cmd.exec) begin
			was_tick <= r_tick;
			tick_time <= r_tick ? tick_q : '0;
			idle <= r_idle;
			running_id <= r_id;
			finished <= r_fin;
			last_tick <= r_last;
			window_over <= r_over;
			arrival_dropped <= r_drop;
		end
	end

endmodule
`default_nettype wire

>>> sv/rrts_checker.sv
// port-level checks for the scheduler top level, with its bind
`default_nettype none
module rrts_checker import rrts_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_stall,
	input wire logic              rsp_valid,
	input wire logic              rsp_stall,
	input wire logic              was_tick,
	input wire logic [TIME_W-1:0] tick_time,
	input wire logic              idle,
	input wire logic [ID_W-1:0]   running_id,
	input wire logic              finished,
	input wire logic              last_tick,
	input wire logic              window_over
);

	// a result waiting on stall stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// one transaction at a time: the block is busy right after accepting
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one still in work");

	// an arrive result carries no tick information
	a_arrive_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !was_tick |-> !idle && !finished && running_id == '0 &&
			!last_tick && !window_over && tick_time == '0)
		else $error("arrive result carries tick fields");

	// a tick past the window does no scheduling
	a_over_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && window_over |-> was_tick && !idle && !finished && !last_tick &&
			running_id == '0)
		else $error("tick past window reported scheduling");

	// an idle tick ran nothing
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && idle |-> was_tick && !finished && running_id == '0 && !window_over)
		else $error("idle tick reported a running job");

endmodule

bind round_robin_tick_scheduler rrts_checker u_rrts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.was_tick   (was_tick),
	.tick_time  (tick_time),
	.idle       (idle),
	.running_id (running_id),
	.finished   (finished),
	.last_tick  (last_tick),
	.window_over(window_over)
);
`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for the round-robin tick scheduler
module tb;
	import rrts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic              command;
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] burst_time;
	} job_req_t;

	typedef struct packed {
		logic              was_tick;
		logic [TIME_W-1:0] tick_time;
		logic              idle;
		logic [ID_W-1:0]   running_id;
		logic              finished;
		logic              last_tick;
		logic              window_over;
		logic              arrival_dropped;
	} sched_result_t;

	typedef struct packed {
		job_req_t      req;
		logic          typed;
		sched_result_t want;
	} pending_req_t;

	typedef struct packed {
		logic              is_cfg;
		logic [TIME_W-1:0] cfg_val;
		pending_req_t      item;
	} plan_row_t;

	localparam sched_result_t NO_RESULT = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [TIME_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic              command = CMD_ARRIVE;
	logic [ID_W-1:0]   job_id = '0;
	logic [TIME_W-1:0] burst_time = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              was_tick;
	logic [TIME_W-1:0] tick_time;
	logic              idle;
	logic [ID_W-1:0]   running_id;
	logic              finished;
	logic              last_tick;
	logic              window_over;
	logic              arrival_dropped;

	round_robin_tick_scheduler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.command        (command),
		.job_id         (job_id),
		.burst_time     (burst_time),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.was_tick       (was_tick),
		.tick_time      (tick_time),
		.idle           (idle),
		.running_id     (running_id),
		.finished       (finished),
		.last_tick      (last_tick),
		.window_over    (window_over),
		.arrival_dropped(arrival_dropped)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// scheduler shadow state
	logic [ID_W-1:0]   ready_ids [QUEUE_DEPTH];
	logic [TIME_W-1:0] ready_left [QUEUE_DEPTH];
	int                rd_ptr = 0;
	int                wr_ptr = 0;
	int                ready_cnt = 0;
	logic [TIME_W-1:0] tick_now = '0;
	logic [TIME_W-1:0] window_len = RUN_LENGTH_RESET;

	pending_req_t  send_q[$];
	sched_result_t sched_q[$];
	pending_req_t  cur_item;
	plan_row_t     plan[$];

	int tx_idle_pct = 23;
	int rx_idle_pct = 45;
	int n_fail = 0;
	int n_items = 0;
	int n_ticks = 0;
	int n_finished = 0;
	int n_idle = 0;
	int n_dropped = 0;
	int n_over = 0;
	int n_last = 0;
	int cycles = 0;

	function automatic void enqueue_job(logic [ID_W-1:0] id, logic [TIME_W-1:0] left);
		ready_ids[wr_ptr] = id;
		ready_left[wr_ptr] = left;
		wr_ptr = (wr_ptr == QUEUE_DEPTH - 1) ? 0 : wr_ptr + 1;
		ready_cnt++;
	endfunction

	function automatic sched_result_t schedule_step(job_req_t r);
		sched_result_t res;
		logic [ID_W-1:0] rid;
		logic [TIME_W-1:0] left;
		res = '0;
		if (r.command == CMD_ARRIVE) begin
			if (ready_cnt >= QUEUE_DEPTH) begin
				res.arrival_dropped = 1'b1;
			end else begin
				enqueue_job(r.job_id, (r.burst_time == '0) ? TIME_W'(1) : r.burst_time);
			end
		end else begin
			res.was_tick = 1'b1;
			res.tick_time = tick_now;
			if (tick_now >= window_len) begin
				res.window_over = 1'b1;
			end else begin
				res.last_tick = (int'(tick_now) + 1 == int'(window_len));
				if (ready_cnt == 0) begin
					res.idle = 1'b1;
				end else begin
					rid = ready_ids[rd_ptr];
					left = ready_left[rd_ptr];
					rd_ptr = (rd_ptr == QUEUE_DEPTH - 1) ? 0 : rd_ptr + 1;
					ready_cnt--;
					if (left != '0)
						left = left - 1'b1;
					res.running_id = rid;
					if (left != '0)
						enqueue_job(rid, left);
					else
						res.finished = 1'b1;
				end
				tick_now = tick_now + 1'b1;
			end
		end
		return res;
	endfunction

	function automatic sched_result_t mk_result(logic wt, logic [TIME_W-1:0] tt, logic idl,
			logic [ID_W-1:0] rid, logic fin, logic lt, logic wo, logic drop);
		sched_result_t res;
		res.was_tick = wt;
		res.tick_time = tt;
		res.idle = idl;
		res.running_id = rid;
		res.finished = fin;
		res.last_tick = lt;
		res.window_over = wo;
		res.arrival_dropped = drop;
		return res;
	endfunction

	function automatic plan_row_t req_row(logic cmd, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] burst, logic typed, sched_result_t want);
		plan_row_t row;
		row = '0;
		row.item.req.command = cmd;
		row.item.req.job_id = id;
		row.item.req.burst_time = burst;
		row.item.typed = typed;
		row.item.want = want;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(logic [TIME_W-1:0] val);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_val = val;
		return row;
	endfunction

	task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			n_fail++;
		end
	endtask

	// block is idle once nothing is queued, offered or outstanding
	task automatic wait_drained();
		do begin
			while (send_q.size() != 0 || req_valid || sched_q.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end while (send_q.size() != 0 || req_valid || sched_q.size() != 0);
	endtask

	task automatic set_window(logic [TIME_W-1:0] len);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_len = len;
	endtask

	// request side: predict on acceptance, then offer the next transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				sched_result_t res;
				res = schedule_step(cur_item.req);
				sched_q.push_back(cur_item.typed ? cur_item.want : res);
				n_items++;
				n_ticks += int'(res.was_tick);
				n_finished += int'(res.finished);
				n_idle += int'(res.idle);
				n_dropped += int'(res.arrival_dropped);
				n_over += int'(res.window_over);
				n_last += int'(res.last_tick);
			end
			if (!req_valid || !req_stall) begin
				if (send_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_item = send_q.pop_front();
					req_valid <= 1'b1;
					command <= cur_item.req.command;
					job_id <= cur_item.req.job_id;
					burst_time <= cur_item.req.burst_time;
				end else begin
					req_valid <= 1'b0;
					command <= 1'($urandom_range(0, 1));
					job_id <= ID_W'($urandom);
					burst_time <= TIME_W'($urandom);
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sched_result_t want;
			if (sched_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tick=%0b time=%0h id=%0h",
					$time, was_tick, tick_time, running_id);
				n_fail++;
			end else begin
				want = sched_q.pop_front();
				check_field("was_tick", TIME_W'(want.was_tick), TIME_W'(was_tick));
				check_field("tick_time", want.tick_time, tick_time);
				check_field("idle", TIME_W'(want.idle), TIME_W'(idle));
				check_field("running_id", TIME_W'(want.running_id), TIME_W'(running_id));
				check_field("finished", TIME_W'(want.finished), TIME_W'(finished));
				check_field("last_tick", TIME_W'(want.last_tick), TIME_W'(last_tick));
				check_field("window_over", TIME_W'(want.window_over), TIME_W'(window_over));
				check_field("arrival_dropped", TIME_W'(want.arrival_dropped),
					TIME_W'(arrival_dropped));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sched_q.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int arrive_pct;
		int sel;
		int n_rand;
		pending_req_t pi;
		logic [TIME_W-1:0] len;

		// directed rows, run length at its reset value
		plan.push_back(req_row(CMD_TICK, 8'h00, 16'h0000, 1'b1,
			mk_result(1'b1, 16'd0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(req_row(CMD_ARRIVE, 8'hFF, 16'h0000, 1'b1, NO_RESULT));
		plan.push_back(req_row(CMD_TICK, 8'h00, 16'h0000, 1'b1,
			mk_result(1'b1, 16'd1, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0)));
		plan.push_back(req_row(CMD_ARRIVE, 8'h00, 16'hFFFF, 1'b1, NO_RESULT));
		plan.push_back(req_row(CMD_ARRIVE, 8'h5A, 16'h0001, 1'b1, NO_RESULT));
		plan.push_back(req_row(CMD_TICK, 8'hFF, 16'hFFFF, 1'b0, NO_RESULT));
		// fill the ready queue to the top
		for (int i = 0; i < 14; i++)
			plan.push_back(req_row(CMD_ARRIVE, ID_W'(8'h10 + i), 16'h0001, 1'b0, NO_RESULT));
		plan.push_back(req_row(CMD_ARRIVE, 8'hEE, 16'h0007, 1'b1,
			mk_result(1'b0, 16'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1)));
		plan.push_back(req_row(CMD_TICK, 8'h00, 16'h0000, 1'b0, NO_RESULT));
		// window closes after tick 4
		plan.push_back(cfg_row(16'd5));
		plan.push_back(req_row(CMD_TICK, 8'h00, 16'h0000, 1'b0, NO_RESULT));
		plan.push_back(req_row(CMD_TICK, 8'h00, 16'h0000, 1'b1,
			mk_result(1'b1, 16'd5, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0)));
		// arrival after the window still gets a free slot
		plan.push_back(req_row(CMD_ARRIVE, 8'hC3, 16'h0003, 1'b1, NO_RESULT));
		plan.push_back(cfg_row(16'd0));
		plan.push_back(req_row(CMD_TICK, 8'h00, 16'h0000, 1'b1,
			mk_result(1'b1, 16'd5, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				wait_drained();
				set_window(plan[k].cfg_val);
			end else begin
				send_q.push_back(plan[k].item);
			end
		end

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: begin
					tx_idle_pct = 23; rx_idle_pct = 45; len = 16'hFFFF; n_rand = 180;
				end
				1: begin
					tx_idle_pct = 45; rx_idle_pct = 23; len = tick_now + 16'd60; n_rand = 180;
				end
				2: begin
					tx_idle_pct = 0; rx_idle_pct = 0; len = 16'hFFFF; n_rand = 165;
				end
				default: begin
					tx_idle_pct = 0; rx_idle_pct = 0; len = 16'd1; n_rand = 20;
				end
			endcase
			set_window(len);
			arrive_pct = 50;
			for (int i = 0; i < n_rand; i++) begin
				// stretches biased toward arrivals or toward ticks
				if (i % 24 == 0)
					arrive_pct = $urandom_range(25, 80);
				pi = '0;
				pi.req.command = ($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_TICK;
				pi.req.job_id = ID_W'($urandom);
				sel = $urandom_range(0, 99);
				if (sel < 1)
					pi.req.burst_time = '1;
				else if (sel < 2)
					pi.req.burst_time = TIME_W'($urandom);
				else if (sel < 8)
					pi.req.burst_time = '0;
				else if (sel < 20)
					pi.req.burst_time = TIME_W'($urandom_range(7, 40));
				else
					pi.req.burst_time = TIME_W'($urandom_range(1, 6));
				send_q.push_back(pi);
			end
		end

		wait_drained();
		$display("%0d transactions, %0d ticks: %0d finished, %0d idle, %0d last, %0d past window",
			n_items, n_ticks, n_finished, n_idle, n_last, n_over);
		$display("%0d arrivals dropped on a full queue, %0d mismatches", n_dropped, n_fail);
		if (n_fail == 0 && sched_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> round_robin_tick_scheduler.f
sv/rrts_pkg.sv
sv/rrts_ram.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_tick_scheduler.sv
sv/rrts_checker.sv
sim/tb.sv
